@@ design/pwmd_pkg.sv @@
// pwmd_pkg: shared types and constants for the pulse-width manchester decoder
// used by the top level, pwmd_cfg and pwmd_core through scoped names; depends on nothing
`default_nettype none

package pwmd_pkg;

  // default bit count limit
  localparam int unsigned MAX_BITS_DEF = 255;

  // configuration port geometry
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  // register indexes (paddr / 4)
  localparam logic [2:0] REG_MIN_PULSE      = 3'd0;
  localparam logic [2:0] REG_MAX_PULSE      = 3'd1;
  localparam logic [2:0] REG_LONG_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_MIN_FRAME_BITS = 3'd3;
  localparam logic [2:0] REG_MAX_PREAMBLE   = 3'd4;

  // register reset values
  localparam logic [15:0] MIN_PULSE_RST      = 16'd200;
  localparam logic [15:0] MAX_PULSE_RST      = 16'd1400;
  localparam logic [15:0] LONG_THRESHOLD_RST = 16'd800;
  localparam logic [7:0]  MIN_FRAME_BITS_RST = 8'd71;
  localparam logic [5:0]  MAX_PREAMBLE_RST   = 6'd32;

  // configuration seen by the decoder core
  typedef struct packed {
    logic [15:0] min_pulse;
    logic [15:0] max_pulse;
    logic [15:0] long_threshold;
    logic [7:0]  min_frame_bits;
    logic [5:0]  max_preamble;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic       bit_valid;
    logic       bit_value;
    logic       frame_done;
    logic [7:0] bit_total;
  } result_t;

endpackage

`default_nettype wire

@@ design/pulse_width_manchester_decoder.sv @@
// a result item goes to the output register, or to the skid register if that is held
// throughput: one item per cycle while in_stall is low; decode state is updated in the accept cycle
// an output register plus a skid register let the input run while a result waits
// reset (rst_n low, synchronous): line idle, counters zero, no result pending,
// configuration registers back to their default values
// top level of the pulse-width manchester decoder; uses pwmd_pkg, pwmd_cfg, pwmd_core
`default_nettype none

module pulse_width_manchester_decoder #(
  parameter int unsigned MAX_BITS = pwmd_pkg::MAX_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [15:0]                  in_duration,
  input  wire logic                         in_level,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_bit_valid,
  output logic                              out_bit_value,
  output logic                              out_frame_done,
  output logic [7:0]                        out_bit_total,
  // configuration port
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [pwmd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [pwmd_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic      [pwmd_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                              cfg_pready
);

  pwmd_pkg::cfg_t    cfg;
  pwmd_pkg::result_t res;
  pwmd_pkg::result_t out_r;
  pwmd_pkg::result_t skid_r;
  logic              out_valid_r;
  logic              skid_valid_r;
  logic              accept;
  logic              out_take;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  pwmd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pwmd_core #(
    .MAX_BITS (MAX_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (accept),
    .duration (in_duration),
    .level    (in_level),
    .cfg      (cfg),
    .res      (res)
  );

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || out_take) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bit_valid  = out_r.bit_valid;
  assign out_bit_value  = out_r.bit_value;
  assign out_frame_done = out_r.frame_done;
  assign out_bit_total  = out_r.bit_total;

endmodule

`default_nettype wire

@@ design/pwmd_cfg.sv @@
// pwmd_cfg: apb-style configuration register file for the decoder
// depends on pwmd_pkg for register indexes, reset values and cfg_t
`default_nettype none

module pwmd_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pwmd_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [pwmd_pkg::CFG_DW-1:0]  pwdata,
  output logic      [pwmd_pkg::CFG_DW-1:0]  prdata,
  output logic                              pready,
  output pwmd_pkg::cfg_t                    cfg
);

  pwmd_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  // register writes, addresses beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_pulse      <= pwmd_pkg::MIN_PULSE_RST;
      cfg_r.max_pulse      <= pwmd_pkg::MAX_PULSE_RST;
      cfg_r.long_threshold <= pwmd_pkg::LONG_THRESHOLD_RST;
      cfg_r.min_frame_bits <= pwmd_pkg::MIN_FRAME_BITS_RST;
      cfg_r.max_preamble   <= pwmd_pkg::MAX_PREAMBLE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        pwmd_pkg::REG_MIN_PULSE:      cfg_r.min_pulse      <= pwdata[15:0];
        pwmd_pkg::REG_MAX_PULSE:      cfg_r.max_pulse      <= pwdata[15:0];
        pwmd_pkg::REG_LONG_THRESHOLD: cfg_r.long_threshold <= pwdata[15:0];
        pwmd_pkg::REG_MIN_FRAME_BITS: cfg_r.min_frame_bits <= pwdata[7:0];
        pwmd_pkg::REG_MAX_PREAMBLE:   cfg_r.max_preamble   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      pwmd_pkg::REG_MIN_PULSE:      prdata = {16'd0, cfg_r.min_pulse};
      pwmd_pkg::REG_MAX_PULSE:      prdata = {16'd0, cfg_r.max_pulse};
      pwmd_pkg::REG_LONG_THRESHOLD: prdata = {16'd0, cfg_r.long_threshold};
      pwmd_pkg::REG_MIN_FRAME_BITS: prdata = {24'd0, cfg_r.min_frame_bits};
      pwmd_pkg::REG_MAX_PREAMBLE:   prdata = {26'd0, cfg_r.max_preamble};
      default:                      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/pwmd_core.sv @@
// pwmd_core: line state, half-bit pairing and bit counter of the decoder
// depends on pwmd_pkg for cfg_t and result_t
`default_nettype none

module pwmd_core #(
  parameter int unsigned MAX_BITS = pwmd_pkg::MAX_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic [15:0]        duration,
  input  wire logic               level,
  input  wire pwmd_pkg::cfg_t     cfg,
  output pwmd_pkg::result_t       res
);

  localparam int unsigned BW = $clog2(MAX_BITS + 1);
  localparam logic [BW-1:0] MAX_CNT = BW'(MAX_BITS);

  // line phase codes
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_PREAMBLE = 3'd1;
  localparam logic [2:0] PH_HIGH     = 3'd2;
  localparam logic [2:0] PH_LOW      = 3'd3;
  localparam logic [2:0] PH_WAIT     = 3'd4;

  // pending half-bit codes
  localparam logic [1:0] HB_NONE = 2'd0;
  localparam logic [1:0] HB_ZERO = 2'd1;
  localparam logic [1:0] HB_ONE  = 2'd2;

  logic [2:0]    phase_r, phase_nxt;
  logic [1:0]    half_r, half_nxt;
  logic [5:0]    pre_r, pre_nxt;
  logic [BW-1:0] cnt_r, cnt_nxt;

  logic            in_window;
  logic            is_long;
  logic            push;
  logic            push_val;
  logic            half_ok;
  logic            done;
  logic [BW+7:0]   cnt_ext;
  logic [BW+7:0]   mfb_ext;
  logic            enough_bits;
  logic [BW+7:0]   total_ext;

  assign in_window   = (duration >= cfg.min_pulse) && (duration <= cfg.max_pulse);
  assign is_long     = duration > cfg.long_threshold;
  assign cnt_ext     = {8'd0, cnt_r};
  assign mfb_ext     = {{BW{1'b0}}, cfg.min_frame_bits};
  assign enough_bits = cnt_ext > mfb_ext;

  // one pulse of line decoding
  always_comb begin
    phase_nxt = phase_r;
    half_nxt  = half_r;
    pre_nxt   = pre_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    push_val  = 1'b0;
    half_ok   = 1'b1;
    done      = 1'b0;

    // pair the half-bit that this phase carries with a pending one
    if (phase_r == PH_HIGH || phase_r == PH_LOW) begin
      case (half_r)
        HB_ZERO: begin
          half_nxt = HB_NONE;
          if (phase_r == PH_HIGH) begin
            push     = 1'b1;
            push_val = 1'b1;
          end else begin
            half_ok = 1'b0;
          end
        end
        HB_ONE: begin
          half_nxt = HB_NONE;
          if (phase_r == PH_LOW) begin
            push     = 1'b1;
            push_val = 1'b0;
          end else begin
            half_ok = 1'b0;
          end
        end
        default: begin
          half_nxt = (phase_r == PH_HIGH) ? HB_ONE : HB_ZERO;
        end
      endcase
    end

    if (!in_window) begin
      // pulse outside the window ends the frame
      push      = 1'b0;
      half_nxt  = HB_NONE;
      phase_nxt = PH_IDLE;
      if (enough_bits) begin
        done = 1'b1;
      end else begin
        cnt_nxt = '0;
      end
    end else begin
      case (phase_r)
        PH_PREAMBLE: begin
          if (is_long) begin
            if (pre_r != 6'd63) begin
              pre_nxt = pre_r + 6'd1;
            end
          end else if (pre_r <= cfg.max_preamble && !level) begin
            phase_nxt = PH_WAIT;
          end else begin
            phase_nxt = PH_IDLE;
            cnt_nxt   = '0;
          end
        end
        PH_HIGH: begin
          if (half_ok) begin
            phase_nxt = is_long ? PH_LOW : PH_WAIT;
          end else begin
            phase_nxt = PH_IDLE;
            cnt_nxt   = '0;
          end
        end
        PH_LOW: begin
          if (half_ok) begin
            phase_nxt = is_long ? PH_HIGH : PH_WAIT;
          end else begin
            phase_nxt = PH_IDLE;
            cnt_nxt   = '0;
          end
        end
        PH_WAIT: begin
          if (is_long) begin
            phase_nxt = PH_IDLE;
            half_nxt  = HB_NONE;
            if (enough_bits) begin
              done = 1'b1;
            end else begin
              cnt_nxt = '0;
            end
          end else begin
            phase_nxt = level ? PH_HIGH : PH_LOW;
          end
        end
        default: begin
          if (is_long) begin
            phase_nxt = PH_PREAMBLE;
            pre_nxt   = 6'd1;
          end else begin
            phase_nxt = PH_IDLE;
            pre_nxt   = 6'd0;
            cnt_nxt   = '0;
          end
        end
      endcase
    end

    // saturating bit counter
    if (push && cnt_r < MAX_CNT) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign total_ext = {8'd0, cnt_nxt};

  // result of this pulse
  always_comb begin
    res.bit_valid  = push;
    res.bit_value  = push && push_val;
    res.frame_done = done;
    res.bit_total  = total_ext[7:0];
  end

  // state update on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      half_r  <= HB_NONE;
      pre_r   <= 6'd0;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      half_r  <= half_nxt;
      pre_r   <= pre_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/pwmd_checker.sv @@
// pwmd_checker: port-level checks for the pulse-width manchester decoder
// bound to the top level below; depends on nothing else
`default_nettype none

module pwmd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_bit_valid,
  input wire logic        out_bit_value,
  input wire logic        out_frame_done,
  input wire logic [7:0]  out_bit_total
);

  // a bit value of one only comes with a decoded bit
  a_value_needs_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bit_value |-> out_bit_valid)
    else $error("bit_value set without bit_valid");

  // a frame end never completes a bit in the same item
  a_done_no_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> !out_bit_valid)
    else $error("frame_done and bit_valid in one item");

  // input backpressure only while a result is pending
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bit_valid)
      && $stable(out_bit_value) && $stable(out_frame_done) && $stable(out_bit_total))
    else $error("stalled result changed");

  // reset leaves both channels empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channel busy after reset");

endmodule

bind pulse_width_manchester_decoder pwmd_checker u_pwmd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_bit_valid  (out_bit_valid),
  .out_bit_value  (out_bit_value),
  .out_frame_done (out_frame_done),
  .out_bit_total  (out_bit_total)
);

`default_nettype wire
